FILE: src/hbi_pkg.sv
// Shared types and constants for the string hash bucket index block.
`default_nettype none
package hbi_pkg;

  localparam int unsigned HASH_W   = 64;
  localparam int unsigned BUCKET_W = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd1;

  localparam logic MODE_DJB2 = 1'b0;
  localparam logic MODE_FNV  = 1'b1;

  localparam logic [HASH_W-1:0]   DJB2_SEED   = 64'd5381;
  localparam logic [HASH_W-1:0]   FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
  // FNV prime is 2^40 + 0x1B3
  localparam int unsigned         FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]          FNV_PRIME_LOW   = 9'h1B3;
  localparam int unsigned         DJB2_SHIFT      = 5;  // *33 = <<5 + 1

  localparam logic [BUCKET_W-1:0] BUCKET_RESET = 32'd1024;

  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);
  localparam int unsigned STEP_W  = $clog2(HASH_W);

  typedef struct packed {
    logic [BYTE_W-1:0] byte_in;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket_index;
    logic [HASH_W-1:0]   full_hash;
  } out_item_t;

  // One finished word waiting for reduction
  typedef struct packed {
    logic [HASH_W-1:0]   hash;
    logic [BUCKET_W-1:0] bucket_count;
  } word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FINISH
  } bk_state_t;

  function automatic logic [HASH_W-1:0] seed_of(input logic mode);
    return (mode == MODE_FNV) ? FNV_BASIS : DJB2_SEED;
  endfunction

endpackage
`default_nettype wire

FILE: src/hbi_front.sv
// Front: configuration registers and per-byte hash accumulation.
`default_nettype none
module hbi_front
  import hbi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  input  wire q_status_t             q_status,
  output logic                       q_push,
  output word_t                      q_word
);

  logic                hash_mode;
  logic [BUCKET_W-1:0] bucket_count;
  logic [HASH_W-1:0]   running_hash;
  logic [HASH_W-1:0]   running_hash_next;
  logic [HASH_W-1:0]   folded;
  logic [HASH_W-1:0]   fnv_x;
  logic [HASH_W-1:0]   byte_ext;
  logic                accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && in_item.last_byte;
  assign byte_ext = HASH_W'(in_item.byte_in);
  assign fnv_x    = running_hash ^ byte_ext;

  always_comb begin
    if (hash_mode == MODE_FNV) begin
      folded = (fnv_x << FNV_PRIME_SHIFT) + HASH_W'(fnv_x * HASH_W'(FNV_PRIME_LOW));
    end else begin
      folded = (running_hash << DJB2_SHIFT) + running_hash + byte_ext;
    end
  end

  assign q_word.hash         = folded;
  assign q_word.bucket_count = bucket_count;

  always_comb begin
    running_hash_next = running_hash;
    if (cfg_we && cfg_index == CFG_HASH_MODE) begin
      running_hash_next = seed_of(cfg_wdata[0]);
    end else if (accept) begin
      running_hash_next = in_item.last_byte ? seed_of(hash_mode) : folded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode    <= MODE_DJB2;
      bucket_count <= BUCKET_RESET;
      running_hash <= DJB2_SEED;
    end else begin
      running_hash <= running_hash_next;
      if (cfg_we && cfg_index == CFG_HASH_MODE) begin
        hash_mode <= cfg_wdata[0];
      end
      if (cfg_we && cfg_index == CFG_BUCKET_COUNT) begin
        bucket_count <= cfg_wdata[BUCKET_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/hbi_queue.sv
// Short queue of finished words between front and back.
`default_nettype none
module hbi_queue
  import hbi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire word_t push_word,
  input  wire logic  pop,
  output word_t      head,
  output q_status_t  status
);

  word_t             mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full  = (count == QCNT_W'(QDEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/hbi_back.sv
// Back: bit-serial 64-by-32 remainder unit with an output register.
`default_nettype none
module hbi_back
  import hbi_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire word_t q_head,
  input  wire q_status_t q_status,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_item
);

  bk_state_t           state;
  bk_state_t           state_next;
  logic [HASH_W-1:0]   hash;
  logic [HASH_W-1:0]   dividend;
  logic [BUCKET_W-1:0] divisor;
  logic [BUCKET_W-1:0] rem;
  logic [STEP_W-1:0]   step;
  logic                load;
  logic                do_step;
  logic                write_out;
  logic                slot_free;
  logic [BUCKET_W:0]   shifted;
  logic                ge;
  logic [BUCKET_W:0]   diff;
  logic [BUCKET_W-1:0] rem_next;

  assign slot_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:   if (!q_status.empty) state_next = BK_RUN;
      BK_RUN:    if (step == STEP_W'(HASH_W - 1)) state_next = BK_FINISH;
      BK_FINISH: if (slot_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    load      = 1'b0;
    do_step   = 1'b0;
    write_out = 1'b0;
    unique case (state)
      BK_IDLE:   load      = !q_status.empty;
      BK_RUN:    do_step   = 1'b1;
      BK_FINISH: write_out = slot_free;
      default:   ;
    endcase
  end

  assign q_pop = load;

  // restoring step: remainder stays below divisor, so 33 bits suffice
  assign shifted  = {rem, dividend[HASH_W-1]};
  assign diff     = shifted - {1'b0, divisor};
  assign ge       = (shifted >= {1'b0, divisor});
  assign rem_next = ge ? diff[BUCKET_W-1:0] : shifted[BUCKET_W-1:0];

  always_ff @(posedge clk) begin
    if (load) begin
      hash     <= q_head.hash;
      dividend <= q_head.hash;
      divisor  <= q_head.bucket_count;
      rem      <= '0;
      step     <= '0;
    end else if (do_step) begin
      dividend <= dividend << 1;
      rem      <= rem_next;
      step     <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (write_out) begin
      out_item.full_hash    <= hash;
      out_item.bucket_index <= (divisor == '0) ? '0 : rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (write_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/string_hash_bucket_index_top.sv
// Top level of the streaming word hash with bucket reduction.
// Words arrive one byte per item; the front folds each byte into a 64-bit
// djb2 or FNV-1a hash with combinational logic, so bytes are taken back
// to back as long as the two-entry word queue has room. Each finished
// word is reduced modulo bucket_count by a bit-serial remainder unit: one
// load, 64 shift-subtract steps, one write to the output register once it
// is free. Short words therefore stall the input once the queue fills;
// words of 66 bytes or more run at one byte per cycle while the output is
// taken. The result waits in its own output register, so the next word's
// reduction proceeds while it is held. A zero bucket_count gives a zero index.
`default_nettype none
module string_hash_bucket_index_top
  import hbi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item
);

  logic      q_push;
  logic      q_pop;
  word_t     q_word;
  word_t     q_head;
  q_status_t q_status;

  hbi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_word    (q_word)
  );

  hbi_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (q_word),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  hbi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_status.full))
    else $error("word pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_status.empty))
    else $error("word popped from empty queue");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_ready && !out_valid)
    else $error("block not empty after reset");

endmodule
`default_nettype wire

FILE: sim/hash_word_checker.sv
// Checker for the string hash block: predicts each word's hash and bucket, compares results.
module hash_word_checker
  import hbi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_item,
  output int                    errors,
  output int                    pending,
  output int                    words_hashed,
  output int                    bytes_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [HASH_W-1:0] DJB_START = 64'd5381;
  localparam logic [HASH_W-1:0] DJB_MUL   = 64'd33;
  localparam logic [HASH_W-1:0] FNV_START = 64'hCBF2_9CE4_8422_2325;
  localparam logic [HASH_W-1:0] FNV_MUL   = 64'h0000_0100_0000_01B3;

  logic                fnv_mode;
  logic [BUCKET_W-1:0] modulus;
  logic [HASH_W-1:0]   word_hash;
  out_item_t           expected_words[$];

  function automatic logic [HASH_W-1:0] start_of(input logic mode);
    return (mode == MODE_FNV) ? FNV_START : DJB_START;
  endfunction

  function automatic logic [HASH_W-1:0] mix_char(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] c,
                                                 input logic mode);
    if (mode == MODE_FNV) begin
      return (h ^ {56'd0, c}) * FNV_MUL;
    end
    return h * DJB_MUL + {56'd0, c};
  endfunction

  function automatic out_item_t close_word(input logic [HASH_W-1:0] h,
                                           input logic [BUCKET_W-1:0] m);
    out_item_t        r;
    logic [HASH_W-1:0] rem;
    rem = (m == '0) ? '0 : h % {32'd0, m};
    r.full_hash = h;
    r.bucket_index = rem[BUCKET_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t         want;
    logic [HASH_W-1:0] h;
    if (rst) begin
      fnv_mode = MODE_DJB2;
      modulus = BUCKET_RESET;
      word_hash = start_of(MODE_DJB2);
      expected_words.delete();
      errors = 0;
      words_hashed = 0;
      bytes_taken = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HASH_MODE: begin
            // any mode write drops a partial word
            fnv_mode = cfg_wdata[0];
            word_hash = start_of(fnv_mode);
          end
          CFG_BUCKET_COUNT: begin
            modulus = cfg_wdata[BUCKET_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        h = mix_char(word_hash, in_item.byte_in, fnv_mode);
        bytes_taken++;
        if (in_item.last_byte) begin
          expected_words.push_back(close_word(h, modulus));
          word_hash = start_of(fnv_mode);
        end else begin
          word_hash = h;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected item: bucket_index %0d full_hash %h",
                 out_item.bucket_index, out_item.full_hash);
          errors++;
        end else begin
          want = expected_words.pop_front();
          words_hashed++;
          if (out_item.bucket_index !== want.bucket_index) begin
            $error("bucket_index: expected %0d, got %0d",
                   want.bucket_index, out_item.bucket_index);
            errors++;
          end
          if (out_item.full_hash !== want.full_hash) begin
            $error("full_hash: expected %h, got %h", want.full_hash, out_item.full_hash);
            errors++;
          end
        end
      end
      pending <= expected_words.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Top of the string hash testbench: clock, reset, byte stimulus, register writes, verdict.
module testbench;
  import hbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 150;
  localparam int SQUEEZE_CYCLES = 600;
  localparam int STALL_LIMIT    = 4000;
  localparam int PHASES         = 6;
  localparam int PHASE_BYTES    = 125;

  // indexes past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  in_item_t              in_item = '0;
  logic                  out_ready = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  out_item_t             out_item;

  int errors;
  int pending;
  int words_hashed;
  int bytes_taken;
  int idle_cycles = 0;
  bit squeeze = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  string_hash_bucket_index_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  hash_word_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_item     (out_item),
    .errors       (errors),
    .pending      (pending),
    .words_hashed (words_hashed),
    .bytes_taken  (bytes_taken)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 30);
    return $urandom_range(60, 140);
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last, input bit steady);
    in_item_t it;
    int       gap;
    it.byte_in = b;
    it.last_byte = last;
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(input int len, input bit steady);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), i == len - 1, steady);
    end
  endtask

  task automatic send_partial(input int len);
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endtask

  // block is idle once every word is out and the reduction stage has drained
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, ready bursts, one long hold-off to back up the word queue
  initial begin
    bit squeezed;
    int r;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(20, 100)) @(posedge clk);
        end else if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          repeat (pick_gap()) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    logic                  cur_mode;
    logic                  next_mode;
    logic [CFG_DATA_W-1:0] next_count;
    int                    len;
    int                    sent;
    bit                    steady;
    cur_mode = MODE_DJB2;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: djb2, 1024 buckets; byte extremes and a three-byte word
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b1, 1'b0);
    settle();
    // stray upper data bits on the mode write; zero bucket count
    write_reg(CFG_HASH_MODE, 32'hFFFF_FFFF);
    cur_mode = MODE_FNV;
    write_reg(CFG_BUCKET_COUNT, 32'd0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h5A, 1'b1, 1'b0);
    settle();
    write_reg(CFG_BUCKET_COUNT, 32'd1);
    push_byte(8'h7E, 1'b1, 1'b0);
    settle();
    write_reg(CFG_BUCKET_COUNT, 32'hFFFF_FFFF);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    // mode change mid-word discards the partial hash
    push_byte(8'h41, 1'b0, 1'b0);
    push_byte(8'h42, 1'b0, 1'b0);
    settle();
    write_reg(CFG_HASH_MODE, 32'h0000_0002);
    cur_mode = MODE_DJB2;
    push_byte(8'h43, 1'b1, 1'b0);
    // rewriting the same mode mid-word also restarts
    push_byte(8'h61, 1'b0, 1'b0);
    settle();
    write_reg(CFG_HASH_MODE, 32'h0000_0000);
    push_byte(8'h62, 1'b1, 1'b0);
    // bucket count change mid-word keeps the partial hash
    push_byte(8'h11, 1'b0, 1'b0);
    push_byte(8'h22, 1'b0, 1'b0);
    settle();
    write_reg(CFG_BUCKET_COUNT, 32'd7);
    push_byte(8'h33, 1'b1, 1'b0);
    settle();
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h01, 1'b1, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      next_mode = (p == 1 || p == 2 || p == 4) ? MODE_FNV : MODE_DJB2;
      case (p)
        0: next_count = BUCKET_RESET;
        1: next_count = 32'hFFFF_FFFF;
        2: next_count = 32'd0;
        3: next_count = 32'd1;
        4: next_count = $urandom;
        default: next_count = $urandom_range(2, 100);
      endcase
      if ($urandom_range(0, 1)) write_reg(CFG_BUCKET_COUNT, next_count);
      if (next_mode != cur_mode || $urandom_range(0, 1)) begin
        write_reg(CFG_HASH_MODE, {31'($urandom), next_mode});
        cur_mode = next_mode;
      end
      write_reg(CFG_BUCKET_COUNT, next_count);
      if ($urandom_range(0, 2) == 0) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                               $urandom);
      if (p == 1) squeeze = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        len = (p == 1 && sent < 60) ? $urandom_range(1, 3) : pick_len();
        steady = ($urandom_range(0, 3) == 0);
        send_word(len, steady);
        sent += len;
      end
      // sometimes leave a word unfinished for the next register writes
      if ($urandom_range(0, 1)) send_partial($urandom_range(1, 3));
    end

    settle();
    $display("Hashed %0d words from %0d bytes in djb2 and FNV-1a, with back-pressure.",
             words_hashed, bytes_taken);
    $display("Bucket counts 0, 1, 7, reset, all ones and random; words cut by register writes.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
